// ----- hw/rtl/int8_conv_dot_requantize_unit_assert.svh -----
// Assertion macros shared by the conv dot / requantize RTL.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef INT8_CONV_DOT_REQUANTIZE_UNIT_ASSERT_SVH
`define INT8_CONV_DOT_REQUANTIZE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CDQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cdq assertion failed");
`define CDQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cdq assertion failed");
`else
`define CDQ_ASSERT_IMP(label, ante, cons)
`define CDQ_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/cdq_pkg.sv -----
// Shared widths, register indexes and bus structs for the conv dot / requantize unit.
// No dependencies.
`default_nettype none

package cdq_pkg;

    localparam int LANES     = 8;
    localparam int BYTE_W    = 8;
    localparam int PACK_W    = 64;
    localparam int PACK_LANES = PACK_W / BYTE_W;
    localparam int IZO_W     = 9;
    localparam int ADJ_W     = IZO_W + 1;
    localparam int PROD_W    = ADJ_W + BYTE_W;
    localparam int SUM_W     = PROD_W + $clog2(LANES);
    localparam int ACC_W     = 32;
    localparam int MULT_W    = 32;
    localparam int WIDE_W    = 2 * MULT_W;
    localparam int RND_W     = ACC_W + 1;
    localparam int SHIFT_W   = 6;
    localparam int OUT_W     = 8;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int REG_IDX_W = 2;

    localparam logic signed [WIDE_W-1:0] NUDGE_POS = WIDE_W'(64'sd1073741824);
    localparam logic signed [WIDE_W-1:0] NUDGE_NEG = WIDE_W'(-64'sd1073741823);
    localparam logic signed [ACC_W-1:0]  Q31_MAX   = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0]  Q31_MIN   = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic signed [OUT_W-1:0] CLAMP_LO_RST = {1'b1, {(OUT_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] CLAMP_HI_RST = {1'b0, {(OUT_W-1){1'b1}}};

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IN_OFFSET  = 2'd0,
        REG_OUT_OFFSET = 2'd1,
        REG_CLAMP_LO   = 2'd2,
        REG_CLAMP_HI   = 2'd3
    } t_reg_idx;

    typedef logic signed [PROD_W-1:0] t_prod;

    // side info that rides along with the lane products
    typedef struct packed {
        logic                      in_image;
        logic                      done;
        logic signed [ACC_W-1:0]   bias;
        logic signed [MULT_W-1:0]  mult;
        logic signed [SHIFT_W-1:0] shift;
    } t_tap_info;

    // finished dot product handed to the requantizer
    typedef struct packed {
        logic signed [ACC_W-1:0]   value;
        logic signed [MULT_W-1:0]  mult;
        logic signed [SHIFT_W-1:0] shift;
    } t_point;

    typedef struct packed {
        logic signed [OUT_W-1:0] out_offset;
        logic signed [OUT_W-1:0] clamp_lo;
        logic signed [OUT_W-1:0] clamp_hi;
    } t_out_cfg;

endpackage

`default_nettype wire

// ----- hw/rtl/cdq_lane.sv -----
// One multiply lane: (sample + input offset) * weight, registered.
// Depends on cdq_pkg.
`default_nettype none

module cdq_lane (
    input  wire logic                             i_clk,
    input  wire logic                             i_load,
    input  wire logic [cdq_pkg::BYTE_W-1:0]       i_sample,
    input  wire logic [cdq_pkg::BYTE_W-1:0]       i_weight,
    input  wire logic signed [cdq_pkg::IZO_W-1:0] i_in_offset,
    output cdq_pkg::t_prod                        o_product
);

    logic signed [cdq_pkg::ADJ_W-1:0] w_adj;
    cdq_pkg::t_prod                   w_prod;
    cdq_pkg::t_prod                   r_product;

    assign w_adj  = cdq_pkg::ADJ_W'(signed'(i_sample)) + cdq_pkg::ADJ_W'(i_in_offset);
    assign w_prod = w_adj * signed'(i_weight);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_product <= w_prod;
        end
    end

    assign o_product = r_product;

endmodule

`default_nettype wire

// ----- hw/rtl/cdq_merge.sv -----
// Lane sum and 32-bit wrapping accumulator; emits one point per done transaction.
// Depends on cdq_pkg and the assertion macro header.
`default_nettype none
`include "int8_conv_dot_requantize_unit_assert.svh"

module cdq_merge (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire cdq_pkg::t_prod     i_products [cdq_pkg::LANES],
    input  wire cdq_pkg::t_tap_info i_info,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output cdq_pkg::t_point         o_point
);

    logic signed [cdq_pkg::SUM_W-1:0] w_sum;
    logic signed [cdq_pkg::SUM_W-1:0] r_b_sum;
    cdq_pkg::t_tap_info               r_b_info;
    logic                             r_b_valid;

    logic [cdq_pkg::ACC_W-1:0]        r_acc;
    logic [cdq_pkg::ACC_W-1:0]        n_acc;
    logic [cdq_pkg::ACC_W-1:0]        w_total;
    cdq_pkg::t_point                  r_c_point;
    logic                             r_c_valid;

    logic                             w_ready_c;
    logic                             w_cons_b;

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < cdq_pkg::LANES; k++) begin
            w_sum = w_sum + cdq_pkg::SUM_W'(i_products[k]);
        end
    end

    // a non-final transaction is absorbed by the accumulator, never blocked downstream
    assign w_ready_c = !r_c_valid || i_ready;
    assign w_cons_b  = !r_b_info.done || w_ready_c;
    assign o_ready   = !r_b_valid || w_cons_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_ready) begin
            r_b_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_b_sum  <= w_sum;
            r_b_info <= i_info;
        end
    end

    assign w_total = r_acc + (r_b_info.in_image ? cdq_pkg::ACC_W'(r_b_sum) : '0);

    always_comb begin
        n_acc = r_acc;
        if (r_b_valid && w_cons_b) begin
            n_acc = r_b_info.done ? '0 : w_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_c_valid <= 1'b0;
        end else begin
            r_acc <= n_acc;
            if (w_ready_c) begin
                r_c_valid <= r_b_valid && r_b_info.done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_c && r_b_valid && r_b_info.done) begin
            r_c_point.value <= signed'(w_total + r_b_info.bias);
            r_c_point.mult  <= r_b_info.mult;
            r_c_point.shift <= r_b_info.shift;
        end
    end

    assign o_valid = r_c_valid;
    assign o_point = r_c_point;

    `CDQ_ASSERT_NXT(a_acc_cleared, r_b_valid && r_b_info.done && w_cons_b, r_acc == '0)
    `CDQ_ASSERT_IMP(a_point_from_done, $rose(r_c_valid), $past(r_b_valid && r_b_info.done))
    `CDQ_ASSERT_NXT(a_done_waits, r_b_valid && r_b_info.done && !w_ready_c,
                    r_b_valid && r_b_info.done)

endmodule

`default_nettype wire

// ----- hw/rtl/cdq_requant.sv -----
// Requantizer pipeline: pre-shift, Q31 rounding high multiply, rounding right
// shift, output offset and clamp, ending in the output register. Depends on cdq_pkg.
`default_nettype none

module cdq_requant (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire cdq_pkg::t_point   i_point,
    input  wire cdq_pkg::t_out_cfg i_cfg,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [cdq_pkg::OUT_W-1:0] o_out_value
);

    // stage D: left pre-shift
    logic                                r_d_valid;
    logic signed [cdq_pkg::ACC_W-1:0]    r_d_shifted;
    logic signed [cdq_pkg::MULT_W-1:0]   r_d_mult;
    logic [cdq_pkg::SHIFT_W-1:0]         r_d_right;
    logic [cdq_pkg::SHIFT_W-2:0]         w_left;
    logic [cdq_pkg::SHIFT_W-1:0]         w_right;
    logic                                w_pos_shift;

    // stage E: full product
    logic                                r_e_valid;
    logic signed [cdq_pkg::WIDE_W-1:0]   r_e_prod;
    logic                                r_e_minmin;
    logic [cdq_pkg::SHIFT_W-1:0]         r_e_right;

    // stage F: high half with rounding
    logic                                r_f_valid;
    logic signed [cdq_pkg::ACC_W-1:0]    r_f_high;
    logic [cdq_pkg::SHIFT_W-1:0]         r_f_right;
    logic signed [cdq_pkg::WIDE_W-1:0]   w_biased;
    logic signed [cdq_pkg::WIDE_W-1:0]   w_floor;
    logic signed [cdq_pkg::WIDE_W-1:0]   w_trunc;

    // stage G: rounding right shift
    logic                                r_g_valid;
    logic signed [cdq_pkg::ACC_W-1:0]    r_g_val;
    logic signed [cdq_pkg::RND_W-1:0]    w_x;
    logic signed [cdq_pkg::RND_W-1:0]    w_q;
    logic [cdq_pkg::RND_W-1:0]           w_mask;
    logic [cdq_pkg::RND_W-1:0]           w_rem;
    logic [cdq_pkg::RND_W-1:0]           w_thr;
    logic [cdq_pkg::RND_W-1:0]           w_rounded;

    // stage H: offset, clamp, output register
    logic                                r_o_valid;
    logic [cdq_pkg::OUT_W-1:0]           r_out_value;
    logic signed [cdq_pkg::RND_W-1:0]    w_v;
    logic signed [cdq_pkg::RND_W-1:0]    w_lo;
    logic signed [cdq_pkg::RND_W-1:0]    w_hi;
    logic signed [cdq_pkg::RND_W-1:0]    w_c1;
    logic signed [cdq_pkg::RND_W-1:0]    w_c2;

    logic w_ready_h, w_ready_g, w_ready_f, w_ready_e, w_ready_d;

    assign w_ready_h = !r_o_valid || !i_stall;
    assign w_ready_g = !r_g_valid || w_ready_h;
    assign w_ready_f = !r_f_valid || w_ready_g;
    assign w_ready_e = !r_e_valid || w_ready_f;
    assign w_ready_d = !r_d_valid || w_ready_e;
    assign o_ready   = w_ready_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (w_ready_d) begin
                r_d_valid <= i_valid;
            end
            if (w_ready_e) begin
                r_e_valid <= r_d_valid;
            end
            if (w_ready_f) begin
                r_f_valid <= r_e_valid;
            end
            if (w_ready_g) begin
                r_g_valid <= r_f_valid;
            end
            if (w_ready_h) begin
                r_o_valid <= r_g_valid;
            end
        end
    end

    // positive shift goes left before the multiply (wraps), else right after it
    assign w_pos_shift = i_point.shift > cdq_pkg::SHIFT_W'(0);
    assign w_left      = w_pos_shift ? i_point.shift[cdq_pkg::SHIFT_W-2:0] : '0;
    assign w_right     = w_pos_shift ? '0 : cdq_pkg::SHIFT_W'(-i_point.shift);

    always_ff @(posedge i_clk) begin
        if (w_ready_d) begin
            r_d_shifted <= i_point.value << w_left;
            r_d_mult    <= i_point.mult;
            r_d_right   <= w_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_e) begin
            r_e_prod   <= r_d_shifted * r_d_mult;
            r_e_minmin <= (r_d_shifted == cdq_pkg::Q31_MIN) && (r_d_mult == cdq_pkg::Q31_MIN);
            r_e_right  <= r_d_right;
        end
    end

    // divide by 2^31 truncating toward zero
    assign w_biased = r_e_prod + (r_e_prod[cdq_pkg::WIDE_W-1] ? cdq_pkg::NUDGE_NEG
                                                              : cdq_pkg::NUDGE_POS);
    assign w_floor  = w_biased >>> (cdq_pkg::MULT_W - 1);
    assign w_trunc  = w_floor + cdq_pkg::WIDE_W'(w_biased[cdq_pkg::WIDE_W-1]
                                                && (|w_biased[cdq_pkg::MULT_W-2:0]));

    always_ff @(posedge i_clk) begin
        if (w_ready_f) begin
            r_f_high  <= r_e_minmin ? cdq_pkg::Q31_MAX : w_trunc[cdq_pkg::ACC_W-1:0];
            r_f_right <= r_e_right;
        end
    end

    // floor shift, then round up when the remainder passes half (ties away from zero)
    assign w_x       = cdq_pkg::RND_W'(r_f_high);
    assign w_q       = w_x >>> r_f_right;
    assign w_mask    = (cdq_pkg::RND_W'(1) << r_f_right) - cdq_pkg::RND_W'(1);
    assign w_rem     = cdq_pkg::RND_W'(w_x) & w_mask;
    assign w_thr     = (w_mask >> 1) + cdq_pkg::RND_W'(r_f_high[cdq_pkg::ACC_W-1]);
    assign w_rounded = w_q + cdq_pkg::RND_W'(w_rem > w_thr);

    always_ff @(posedge i_clk) begin
        if (w_ready_g) begin
            r_g_val <= signed'(w_rounded[cdq_pkg::ACC_W-1:0]);
        end
    end

    // low limit first, then high limit, so the high limit wins when they cross
    assign w_v  = cdq_pkg::RND_W'(r_g_val) + cdq_pkg::RND_W'(i_cfg.out_offset);
    assign w_lo = cdq_pkg::RND_W'(i_cfg.clamp_lo);
    assign w_hi = cdq_pkg::RND_W'(i_cfg.clamp_hi);
    assign w_c1 = (w_v < w_lo) ? w_lo : w_v;
    assign w_c2 = (w_c1 > w_hi) ? w_hi : w_c1;

    always_ff @(posedge i_clk) begin
        if (w_ready_h) begin
            r_out_value <= w_c2[cdq_pkg::OUT_W-1:0];
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_value = r_out_value;

endmodule

`default_nettype wire

// ----- hw/rtl/int8_conv_dot_requantize_unit.sv -----
// Top level of the int8 conv dot product / per-channel requantize unit.
// Depends on cdq_pkg, cdq_lane, cdq_merge and cdq_requant.
`default_nettype none

// Accepts one transaction per clock while o_stall is low: eight int8
// sample/weight pairs are multiplied in parallel lanes, summed and added
// into a 32-bit wrapping accumulator; the transaction flagged point_done
// adds the channel bias and sends the sum through the requantizer. Its
// result passes eight register stages before it shows on o_valid. The lane
// multipliers and the accumulator add are registered and set the rate of one
// transaction per cycle; the stages are elastic, so input keeps flowing while
// a result waits on o_valid until there is no free stage left. Registers: 0x0
// input offset, 0x4 output offset, 0x8 clamp low, 0xC clamp high; write them
// only while the unit is idle.
module int8_conv_dot_requantize_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [cdq_pkg::PACK_W-1:0]         i_sample_bytes,
    input  wire logic [cdq_pkg::PACK_W-1:0]         i_weight_bytes,
    input  wire logic                               i_tap_inside,
    input  wire logic                               i_point_done,
    input  wire logic signed [cdq_pkg::ACC_W-1:0]   i_channel_bias,
    input  wire logic signed [cdq_pkg::MULT_W-1:0]  i_scale_multiplier,
    input  wire logic signed [cdq_pkg::SHIFT_W-1:0] i_scale_shift,
    // output channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [cdq_pkg::OUT_W-1:0]        o_out_value,
    // register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [cdq_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [cdq_pkg::DATA_W-1:0]         pwdata,
    output logic [cdq_pkg::DATA_W-1:0]              prdata,
    output logic                                    pready
);

    logic signed [cdq_pkg::IZO_W-1:0] r_in_offset;
    logic signed [cdq_pkg::OUT_W-1:0] r_out_offset;
    logic signed [cdq_pkg::OUT_W-1:0] r_clamp_lo;
    logic signed [cdq_pkg::OUT_W-1:0] r_clamp_hi;
    cdq_pkg::t_reg_idx                w_reg_idx;
    logic                             w_wr;
    cdq_pkg::t_out_cfg                w_out_cfg;

    logic                             r_a_valid;
    cdq_pkg::t_tap_info               r_a_info;
    logic                             w_ready_a;
    logic                             w_merge_ready;
    cdq_pkg::t_prod                   w_products [cdq_pkg::LANES];

    logic                             w_pt_valid;
    logic                             w_rq_ready;
    cdq_pkg::t_point                  w_point;
    logic [cdq_pkg::OUT_W-1:0]        w_out_value;

    // register port
    assign pready    = 1'b1;
    assign w_reg_idx = cdq_pkg::t_reg_idx'(
        paddr[cdq_pkg::ADDR_W-1:cdq_pkg::ADDR_W-cdq_pkg::REG_IDX_W]);
    assign w_wr      = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_offset  <= '0;
            r_out_offset <= '0;
            r_clamp_lo   <= cdq_pkg::CLAMP_LO_RST;
            r_clamp_hi   <= cdq_pkg::CLAMP_HI_RST;
        end else if (w_wr) begin
            case (w_reg_idx)
                cdq_pkg::REG_IN_OFFSET:  r_in_offset  <= signed'(pwdata[cdq_pkg::IZO_W-1:0]);
                cdq_pkg::REG_OUT_OFFSET: r_out_offset <= signed'(pwdata[cdq_pkg::OUT_W-1:0]);
                cdq_pkg::REG_CLAMP_LO:   r_clamp_lo   <= signed'(pwdata[cdq_pkg::OUT_W-1:0]);
                cdq_pkg::REG_CLAMP_HI:   r_clamp_hi   <= signed'(pwdata[cdq_pkg::OUT_W-1:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            cdq_pkg::REG_IN_OFFSET:  prdata = cdq_pkg::DATA_W'(r_in_offset);
            cdq_pkg::REG_OUT_OFFSET: prdata = cdq_pkg::DATA_W'(r_out_offset);
            cdq_pkg::REG_CLAMP_LO:   prdata = cdq_pkg::DATA_W'(r_clamp_lo);
            cdq_pkg::REG_CLAMP_HI:   prdata = cdq_pkg::DATA_W'(r_clamp_hi);
            default:                 prdata = '0;
        endcase
    end

    assign w_out_cfg.out_offset = r_out_offset;
    assign w_out_cfg.clamp_lo   = r_clamp_lo;
    assign w_out_cfg.clamp_hi   = r_clamp_hi;

    // stage A: lane products plus side info
    assign w_ready_a = !r_a_valid || w_merge_ready;
    assign o_stall   = !w_ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ready_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a) begin
            r_a_info.in_image <= i_tap_inside;
            r_a_info.done     <= i_point_done;
            r_a_info.bias     <= i_channel_bias;
            r_a_info.mult     <= i_scale_multiplier;
            r_a_info.shift    <= i_scale_shift;
        end
    end

    for (genvar g = 0; g < cdq_pkg::LANES; g++) begin : g_lane
        logic [cdq_pkg::BYTE_W-1:0] w_s;
        logic [cdq_pkg::BYTE_W-1:0] w_w;
        // lanes past the packed width see zero bytes
        if (g < cdq_pkg::PACK_LANES) begin : g_packed
            assign w_s = i_sample_bytes[g*cdq_pkg::BYTE_W +: cdq_pkg::BYTE_W];
            assign w_w = i_weight_bytes[g*cdq_pkg::BYTE_W +: cdq_pkg::BYTE_W];
        end else begin : g_empty
            assign w_s = '0;
            assign w_w = '0;
        end
        cdq_lane u_lane (
            .i_clk       (i_clk),
            .i_load      (w_ready_a),
            .i_sample    (w_s),
            .i_weight    (w_w),
            .i_in_offset (r_in_offset),
            .o_product   (w_products[g])
        );
    end

    cdq_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_a_valid),
        .o_ready    (w_merge_ready),
        .i_products (w_products),
        .i_info     (r_a_info),
        .o_valid    (w_pt_valid),
        .i_ready    (w_rq_ready),
        .o_point    (w_point)
    );

    cdq_requant u_requant (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_pt_valid),
        .o_ready     (w_rq_ready),
        .i_point     (w_point),
        .i_cfg       (w_out_cfg),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_value (w_out_value)
    );

    assign o_out_value = signed'(w_out_value);

endmodule

`default_nettype wire

// ----- tb/sv/int8_conv_dot_requantize_unit_checker.sv -----
// Checker for the int8 conv dot / requantize unit: watches both channels and the register port,
// predicts every out_value from its own copy of the accumulator and registers, and counts mismatches.
// Depends on cdq_pkg.
module int8_conv_dot_requantize_unit_checker
    import cdq_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // input channel as seen at the block
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [PACK_W-1:0]         i_sample_bytes,
    input  logic [PACK_W-1:0]         i_weight_bytes,
    input  logic                      i_tap_inside,
    input  logic                      i_point_done,
    input  logic signed [ACC_W-1:0]   i_channel_bias,
    input  logic signed [MULT_W-1:0]  i_scale_multiplier,
    input  logic signed [SHIFT_W-1:0] i_scale_shift,
    // output channel
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic signed [OUT_W-1:0]   i_out_value,
    // register port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic                      pready,
    input  logic [ADDR_W-1:0]         paddr,
    input  logic [DATA_W-1:0]         pwdata,
    // end of run: anything still queued is a failure
    input  logic                      i_final_check,
    output int                        o_fail_count,
    output int                        o_pending
);

    int in_offset;
    int out_offset;
    int clamp_lo;
    int clamp_hi;
    logic [ACC_W-1:0] dot_sum;
    logic signed [OUT_W-1:0] expected_outputs[$];
    logic signed [OUT_W-1:0] next_want;
    bit final_done;
    int result_index;

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 result_index, what, got, want);
        o_fail_count++;
    endtask

    // sum over the lanes of (sample + input offset) * weight, wrapping at 32 bits
    function automatic logic [ACC_W-1:0] tap_dot(input logic [PACK_W-1:0] smp,
                                                  input logic [PACK_W-1:0] wgt);
        int lane;
        int s;
        int w;
        int total;
        total = 0;
        for (lane = 0; lane < LANES && lane < PACK_LANES; lane++) begin
            s = $signed(smp[lane*BYTE_W +: BYTE_W]);
            s = s + in_offset;
            w = $signed(wgt[lane*BYTE_W +: BYTE_W]);
            total += s * w;
        end
        return total;
    endfunction

    // left pre-shift, rounding doubling high multiply, rounding right shift,
    // output offset and clamp
    function automatic logic signed [OUT_W-1:0] requantize_point(
        input logic [ACC_W-1:0]         acc,
        input logic signed [MULT_W-1:0] mult,
        input logic signed [SHIFT_W-1:0] shift
    );
        int sh;
        int left_n;
        int right_n;
        logic [ACC_W-1:0] shifted;
        longint a;
        longint b;
        longint prod;
        longint nudge;
        longint high;
        longint d;
        longint q;
        longint rem;
        longint thr;
        longint v;
        sh = shift;
        if (sh > 0) begin
            left_n  = sh;
            right_n = 0;
        end else begin
            left_n  = 0;
            right_n = -sh;
        end
        shifted = acc << left_n;
        a = $signed(shifted);
        b = mult;
        if (a == -64'sd2147483648 && b == -64'sd2147483648) begin
            high = 64'sd2147483647;
        end else begin
            prod  = a * b;
            nudge = (prod >= 0) ? 64'sd1073741824 : -64'sd1073741823;
            high  = (prod + nudge) / 64'sd2147483648;
        end
        // floor division, then round half away from zero on the remainder
        d = 64'sd1 <<< right_n;
        q = high / d;
        if ((high % d) != 0 && high < 0) q = q - 1;
        rem = high - q * d;
        thr = ((d - 1) >>> 1) + ((high < 0) ? 64'sd1 : 64'sd0);
        v = q + ((rem > thr) ? 64'sd1 : 64'sd0);
        v = v + out_offset;
        if (v < clamp_lo) v = clamp_lo;
        if (v > clamp_hi) v = clamp_hi;
        return v[OUT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_offset    = 0;
            out_offset   = 0;
            clamp_lo     = -128;
            clamp_hi     = 127;
            dot_sum      = '0;
            expected_outputs.delete();
            o_fail_count = 0;
            final_done   = 1'b0;
            result_index = 0;
        end else begin
            // compare first so a result never matches a prediction made this cycle
            if (i_out_valid && !i_out_stall) begin
                if (expected_outputs.size() == 0) begin
                    report_mismatch("unexpected result, out_value", i_out_value, 0);
                end else begin
                    next_want = expected_outputs.pop_front();
                    if (i_out_value !== next_want)
                        report_mismatch("out_value", i_out_value, next_want);
                end
                result_index++;
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_tap_inside)
                    dot_sum = dot_sum + tap_dot(i_sample_bytes, i_weight_bytes);
                if (i_point_done) begin
                    dot_sum = dot_sum + i_channel_bias;
                    expected_outputs.push_back(
                        requantize_point(dot_sum, i_scale_multiplier, i_scale_shift));
                    dot_sum = '0;
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[ADDR_W-1:2]))
                    REG_IN_OFFSET:  in_offset  = $signed(pwdata[IZO_W-1:0]);
                    REG_OUT_OFFSET: out_offset = $signed(pwdata[OUT_W-1:0]);
                    REG_CLAMP_LO:   clamp_lo   = $signed(pwdata[OUT_W-1:0]);
                    REG_CLAMP_HI:   clamp_hi   = $signed(pwdata[OUT_W-1:0]);
                    default: ;
                endcase
            end
            if (i_final_check && !final_done) begin
                final_done = 1'b1;
                if (expected_outputs.size() != 0)
                    report_mismatch("results never delivered, count", 0,
                                    expected_outputs.size());
            end
        end
        o_pending = expected_outputs.size();
    end

endmodule

// ----- tb/sv/tb_int8_conv_dot_requantize_unit.sv -----
// Testbench top for int8_conv_dot_requantize_unit: clock, reset, register writes, stimulus,
// receiver stalls, watchdog and verdict. Depends on cdq_pkg, the unit and the checker module.
module tb_int8_conv_dot_requantize_unit;
    import cdq_pkg::*;

    localparam int TARGET_ITEMS   = 800;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 6;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_valid;
    logic                      o_stall;
    logic [PACK_W-1:0]         i_sample_bytes;
    logic [PACK_W-1:0]         i_weight_bytes;
    logic                      i_tap_inside;
    logic                      i_point_done;
    logic signed [ACC_W-1:0]   i_channel_bias;
    logic signed [MULT_W-1:0]  i_scale_multiplier;
    logic signed [SHIFT_W-1:0] i_scale_shift;
    logic                      o_valid;
    logic                      i_stall;
    logic signed [OUT_W-1:0]   o_out_value;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [ADDR_W-1:0]         paddr;
    logic [DATA_W-1:0]         pwdata;
    logic [DATA_W-1:0]         prdata;
    logic                      pready;

    logic final_check;
    int   fail_count;
    int   pending;
    int   items_sent;
    bit   calm;       // no idling on either side
    bit   hold_req;   // receiver holds off for a long stretch
    int   idle_cycles;

    int8_conv_dot_requantize_unit DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_sample_bytes     (i_sample_bytes),
        .i_weight_bytes     (i_weight_bytes),
        .i_tap_inside       (i_tap_inside),
        .i_point_done       (i_point_done),
        .i_channel_bias     (i_channel_bias),
        .i_scale_multiplier (i_scale_multiplier),
        .i_scale_shift      (i_scale_shift),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_out_value        (o_out_value),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    int8_conv_dot_requantize_unit_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_valid),
        .i_in_stall         (o_stall),
        .i_sample_bytes     (i_sample_bytes),
        .i_weight_bytes     (i_weight_bytes),
        .i_tap_inside       (i_tap_inside),
        .i_point_done       (i_point_done),
        .i_channel_bias     (i_channel_bias),
        .i_scale_multiplier (i_scale_multiplier),
        .i_scale_shift      (i_scale_shift),
        .i_out_valid        (o_valid),
        .i_out_stall        (i_stall),
        .i_out_value        (o_out_value),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .pready             (pready),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .i_final_check      (final_check),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // receiver: random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_stall <= !calm && ($urandom_range(99) < 33);
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    task automatic send_item(input logic [PACK_W-1:0] smp, input logic [PACK_W-1:0] wgt,
                             input logic ins, input logic done,
                             input logic [ACC_W-1:0] bias, input logic [MULT_W-1:0] mult,
                             input logic [SHIFT_W-1:0] shf);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 33) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_sample_bytes     <= smp;
        i_weight_bytes     <= wgt;
        i_tap_inside       <= ins;
        i_point_done       <= done;
        i_channel_bias     <= bias;
        i_scale_multiplier <= mult;
        i_scale_shift      <= shf;
        i_valid            <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        items_sent++;
    endtask

    task automatic write_reg(input t_reg_idx idx, input int value);
        logic [DATA_W-1:0] keep;
        logic [DATA_W-1:0] data;
        keep = (idx == REG_IN_OFFSET) ? 32'h1FF : 32'hFF;
        // bits above the register width are junk on purpose
        data = ($urandom & ~keep) | (DATA_W'(value) & keep);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop sending, let every result arrive, then give the pipeline time to empty
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [PACK_W-1:0] rand_bytes();
        logic [PACK_W-1:0] v;
        int r;
        int lane;
        r = $urandom_range(99);
        if (r < 70) begin
            v = {$urandom, $urandom};
        end else if (r < 85) begin
            for (lane = 0; lane < PACK_LANES; lane++) begin
                case ($urandom_range(3))
                    0: v[lane*BYTE_W +: BYTE_W] = 8'h80;
                    1: v[lane*BYTE_W +: BYTE_W] = 8'h7F;
                    2: v[lane*BYTE_W +: BYTE_W] = 8'hFF;
                    default: v[lane*BYTE_W +: BYTE_W] = 8'h00;
                endcase
            end
        end else begin
            for (lane = 0; lane < PACK_LANES; lane++)
                v[lane*BYTE_W +: BYTE_W] = BYTE_W'($urandom_range(8) - 4);
        end
        return v;
    endfunction

    function automatic logic [ACC_W-1:0] rand_bias();
        int r;
        r = $urandom_range(99);
        if (r < 50) return ACC_W'($urandom_range(2000) - 1000);
        if (r < 80) return $urandom;
        case ($urandom_range(2))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic [MULT_W-1:0] rand_mult();
        int r;
        r = $urandom_range(99);
        if (r < 60) return $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
        if (r < 80) return $urandom;
        case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h1;
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic [SHIFT_W-1:0] rand_shift();
        int r;
        int t;
        r = $urandom_range(99);
        if (r < 60) begin
            t = $urandom_range(12);
            return SHIFT_W'(-t);
        end
        if (r < 75) return SHIFT_W'($urandom_range(4));
        return SHIFT_W'($urandom_range(63));
    endfunction

    task automatic send_random_point(input int len);
        int k;
        for (k = 0; k < len; k++)
            send_item(rand_bytes(), rand_bytes(), $urandom_range(9) != 0, k == len - 1,
                      rand_bias(), rand_mult(), rand_shift());
    endtask

    function automatic int rand_len();
        int r;
        r = $urandom_range(99);
        if (r < 50) return $urandom_range(3, 1);
        if (r < 90) return $urandom_range(8, 4);
        return $urandom_range(24, 9);
    endfunction

    // runs at reset register values
    task automatic run_directed();
        send_item(64'h0, 64'h0, 1'b1, 1'b1, 32'h0, 32'h0, 6'h0);
        send_item({8{8'h7F}}, {8{8'h7F}}, 1'b1, 1'b1, 32'h0, 32'h7FFF_FFFF, -6'sd8);
        send_item({8{8'h80}}, {8{8'h7F}}, 1'b1, 1'b1, 32'h0, 32'h7FFF_FFFF, -6'sd8);
        send_item({8{8'h80}}, {8{8'h80}}, 1'b1, 1'b1, 32'h0, 32'h7FFF_FFFF, -6'sd10);
        send_item({8{8'hFF}}, {8{8'h7F}}, 1'b1, 1'b1, 32'h0, 32'h7FFF_FFFF, 6'h0);
        // point over several items, one tap outside the image
        send_item(64'h0102_0304_0506_0708, 64'h0101_0101_0101_0101, 1'b1, 1'b0,
                  32'h0, 32'h0, 6'h0);
        send_item({8{8'h7F}}, {8{8'h7F}}, 1'b0, 1'b0, 32'h0, 32'h0, 6'h0);
        send_item(64'h80FF_7F01_0080_FF7F, 64'h7F80_0102_FF80_7F01, 1'b1, 1'b1,
                  32'sd1000, 32'h4000_0000, -6'sd4);
        // last item outside the image: bias alone
        send_item({8{8'h55}}, {8{8'hAA}}, 1'b0, 1'b1, 32'sd5000, 32'h7FFF_FFFF, -6'sd6);
        // pre-shift left wraps
        send_item(64'h0, 64'h0, 1'b0, 1'b1, 32'h4000_0001, 32'h7FFF_FFFF, 6'sd2);
        send_item(64'h0, 64'h0, 1'b0, 1'b1, 32'h1, 32'h8000_0000, 6'sd31);
        send_item(64'h0, 64'h0, 1'b0, 1'b1, 32'sd3, 32'sd100, 6'sd31);
        // both operands at the minimum
        send_item(64'h0, 64'h0, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, 6'h0);
        // right shift by 32 and by 31
        send_item(64'h0, 64'h0, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'h20);
        send_item(64'h0, 64'h0, 1'b0, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 6'h20);
        send_item(64'h0, 64'h0, 1'b0, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -6'sd31);
        send_item(64'h0, 64'h0, 1'b0, 1'b1, 32'h8000_0000, 32'h8000_0000, -6'sd31);
        send_item({8{8'h7F}}, {8{8'h7F}}, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h0, 6'h0);
        send_item(64'h0, 64'h0, 1'b1, 1'b1, 32'sd50, 32'h8000_0001, 6'h0);
        // bias wraps the accumulator negative
        send_item({8{8'h7F}}, {8{8'h7F}}, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -6'sd24);
        send_item(64'h0, 64'h0, 1'b0, 1'b1, -32'sd77, 32'h7FFF_FFFF, -6'sd1);
        send_item(64'h0, 64'h0, 1'b0, 1'b1, -32'sd5, 32'h7FFF_FFFF, -6'sd1);
    endtask

    initial begin
        int ph;
        int phase_end;
        int izo;
        int ozo;
        int lo;
        int hi;
        int tmp;
        int k;
        bit pressure_done;

        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_sample_bytes     = '0;
        i_weight_bytes     = '0;
        i_tap_inside       = 1'b0;
        i_point_done       = 1'b0;
        i_channel_bias     = '0;
        i_scale_multiplier = '0;
        i_scale_shift      = '0;
        i_stall            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        final_check        = 1'b0;
        items_sent         = 0;
        calm               = 1'b0;
        hold_req           = 1'b0;
        idle_cycles        = 0;
        pressure_done      = 1'b0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        for (ph = 1; ph <= NUM_PHASES; ph++) begin
            settle();
            case (ph)
                1: begin izo = -128; ozo = 127;  lo = -128; hi = 127; end
                2: begin izo = 128;  ozo = -128; lo = -128; hi = 127; end
                3: begin izo = 7;    ozo = -3;   lo = 50;   hi = -50; end  // crossed limits
                4: begin izo = -1;   ozo = 0;    lo = -20;  hi = 20;  end
                default: begin
                    izo = $urandom_range(511) - 256;
                    ozo = $urandom_range(255) - 128;
                    lo  = $urandom_range(255) - 128;
                    hi  = $urandom_range(255) - 128;
                    if (ph == NUM_PHASES && lo > hi) begin
                        tmp = lo;
                        lo  = hi;
                        hi  = tmp;
                    end
                end
            endcase
            write_reg(REG_IN_OFFSET, izo);
            write_reg(REG_OUT_OFFSET, ozo);
            write_reg(REG_CLAMP_LO, lo);
            write_reg(REG_CLAMP_HI, hi);

            calm = (ph == 4);
            phase_end = items_sent + (TARGET_ITEMS - items_sent) / (NUM_PHASES + 1 - ph);
            while (items_sent < phase_end) begin
                if (ph == 2 && !pressure_done && items_sent > phase_end - 60) begin
                    // receiver holds off while short points keep coming
                    pressure_done = 1'b1;
                    hold_req      = 1'b1;
                    for (k = 0; k < 40; k++)
                        send_random_point(1);
                end
                send_random_point(rand_len());
            end
            calm = 1'b0;
        end

        settle();
        final_check <= 1'b1;
        @(negedge i_clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
